@@ hdl/stack_vm_call_return_core_defines.svh @@
// ----------------------------------------------------------------------------
// Stack VM call/return core - assertion macros
// Concurrent check wrappers; define ASSERT_OFF to compile them out.
// ----------------------------------------------------------------------------
`ifndef STACK_VM_CALL_RETURN_CORE_DEFINES_SVH
`define STACK_VM_CALL_RETURN_CORE_DEFINES_SVH

`ifndef ASSERT_OFF
`define SVCR_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("svcr check failed");
`define SVCR_ASSERT_NORST(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("svcr check failed");
`else
`define SVCR_ASSERT(lbl, clk, rst_n, prop)
`define SVCR_ASSERT_NORST(lbl, clk, prop)
`endif

`endif

@@ hdl/svcr_pkg.sv @@
// ----------------------------------------------------------------------------
// svcr_pkg
// Shared types and constants of the stack VM call/return core.
// ----------------------------------------------------------------------------
package svcr_pkg;

  localparam int SVCR_STACK_BYTES  = 256;
  localparam int SVCR_CALL_DEPTH   = 16;
  localparam int SVCR_OPCODE_BYTES = 2;
  localparam int WORD_BYTES        = 2;
  localparam int QUEUE_DEPTH       = 2;

  localparam int CMD_W   = 3;
  localparam int WORD_W  = 16;
  localparam int LEVEL_W = 9;
  localparam int CALL_W  = 5;
  localparam int FAULT_W = 3;

  typedef enum logic [CMD_W-1:0] {
    CMD_HALT  = 3'd0,
    CMD_PUSH  = 3'd1,
    CMD_POP   = 3'd2,
    CMD_CALL  = 3'd3,
    CMD_RETN  = 3'd4,
    CMD_RETV  = 3'd5,
    CMD_NOP_A = 3'd6,
    CMD_NOP_B = 3'd7
  } cmd_t;

  typedef enum logic [2:0] {
    OP_NOP,
    OP_HALT,
    OP_PUSH,
    OP_POP,
    OP_CALL,
    OP_RETN,
    OP_RETV
  } op_t;

  typedef enum logic [FAULT_W-1:0] {
    FAULT_NONE      = 3'd0,
    FAULT_STACK_OVF = 3'd1,
    FAULT_STACK_UNF = 3'd2,
    FAULT_CALL_OVF  = 3'd3,
    FAULT_CALL_UNF  = 3'd4,
    FAULT_FRAME     = 3'd5
  } fault_t;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_EXEC
  } state_t;

  typedef struct packed {
    op_t               op;
    logic [WORD_W-1:0] operand;
  } req_t;

  typedef struct packed {
    logic [WORD_W-1:0]  next_address;
    logic [WORD_W-1:0]  result_value;
    logic [LEVEL_W-1:0] stack_level;
    logic [LEVEL_W-1:0] frame_level;
    logic [CALL_W-1:0]  call_level;
    logic               is_halted;
    fault_t             fault;
  } res_t;

  typedef struct packed {
    logic clearing;
    logic halted;
  } bk_stat_t;

endpackage

@@ hdl/svcr_if.sv @@
// ----------------------------------------------------------------------------
// svcr channel interfaces
// Valid/ready request channels for instructions and results.
// ----------------------------------------------------------------------------
interface svcr_in_if import svcr_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CMD_W-1:0]  cmd;
  logic [WORD_W-1:0] operand;

  modport source (output valid, cmd, operand, input ready);
  modport sink   (input valid, cmd, operand, output ready);
endinterface

interface svcr_out_if import svcr_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [WORD_W-1:0]  next_address;
  logic [WORD_W-1:0]  result_value;
  logic [LEVEL_W-1:0] stack_level;
  logic [LEVEL_W-1:0] frame_level;
  logic [CALL_W-1:0]  call_level;
  logic               is_halted;
  logic [FAULT_W-1:0] fault;

  modport source (output valid, next_address, result_value, stack_level, frame_level,
                  call_level, is_halted, fault, input ready);
  modport sink   (input valid, next_address, result_value, stack_level, frame_level,
                  call_level, is_halted, fault, output ready);
endinterface

@@ hdl/svcr_ram.sv @@
// ----------------------------------------------------------------------------
// svcr_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module svcr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                       clk,
  input  logic                                       we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                           wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                           rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ hdl/svcr_front.sv @@
// ----------------------------------------------------------------------------
// svcr_front
// Accepts instruction requests and classifies the opcode.
// ----------------------------------------------------------------------------
module svcr_front import svcr_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  svcr_in_if.sink          in_ch,
  output logic             fq_vld,
  input  logic             fq_rdy,
  output req_t             fq_req
);

  logic vld_r;
  logic vld_nxt;
  req_t req_r;
  req_t req_nxt;
  logic accept;

  assign in_ch.ready = !vld_r || fq_rdy;
  assign accept      = in_ch.valid && in_ch.ready;

  always_comb begin
    req_nxt.operand = in_ch.operand;
    case (in_ch.cmd)
      CMD_HALT: req_nxt.op = OP_HALT;
      CMD_PUSH: req_nxt.op = OP_PUSH;
      CMD_POP:  req_nxt.op = OP_POP;
      CMD_CALL: req_nxt.op = OP_CALL;
      CMD_RETN: req_nxt.op = OP_RETN;
      CMD_RETV: req_nxt.op = OP_RETV;
      default:  req_nxt.op = OP_NOP;
    endcase
  end

  always_comb begin
    vld_nxt = vld_r;
    if (accept) begin
      vld_nxt = 1'b1;
    end else if (fq_rdy) begin
      vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req_r <= req_nxt;
    end
  end

  assign fq_vld = vld_r;
  assign fq_req = req_r;

endmodule

@@ hdl/svcr_queue.sv @@
// ----------------------------------------------------------------------------
// svcr_queue
// Short request queue between the front and the back.
// ----------------------------------------------------------------------------
module svcr_queue import svcr_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic wr_vld,
  output logic wr_rdy,
  input  req_t wr_req,
  output logic rd_vld,
  input  logic rd_rdy,
  output req_t rd_req
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST = PTR_W'(QUEUE_DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL = CNT_W'(QUEUE_DEPTH);

  req_t             slot_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wp_r;
  logic [PTR_W-1:0] wp_nxt;
  logic [PTR_W-1:0] rp_r;
  logic [PTR_W-1:0] rp_nxt;
  logic [CNT_W-1:0] cnt_r;
  logic [CNT_W-1:0] cnt_nxt;
  logic             push;
  logic             pop;

  assign wr_rdy = cnt_r != FULL;
  assign rd_vld = cnt_r != '0;
  assign rd_req = slot_r[rp_r];
  assign push   = wr_vld && wr_rdy;
  assign pop    = rd_vld && rd_rdy;

  always_comb begin
    wp_nxt  = wp_r;
    rp_nxt  = rp_r;
    cnt_nxt = cnt_r;
    if (push) begin
      wp_nxt = (wp_r == LAST) ? '0 : wp_r + 1'b1;
    end
    if (pop) begin
      rp_nxt = (rp_r == LAST) ? '0 : rp_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wp_r] <= wr_req;
    end
  end

endmodule

@@ hdl/svcr_back.sv @@
// ----------------------------------------------------------------------------
// svcr_back
// Executes instructions against the byte stack and the call-record stack.
// ----------------------------------------------------------------------------
module svcr_back import svcr_pkg::*; #(
  parameter int STACK_BYTES  = SVCR_STACK_BYTES,
  parameter int CALL_DEPTH   = SVCR_CALL_DEPTH,
  parameter int OPCODE_BYTES = SVCR_OPCODE_BYTES
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        bq_vld,
  output logic        bq_rdy,
  input  req_t        bq_req,
  svcr_out_if.source  out_ch,
  output bk_stat_t    stat
);

  localparam int PTR_W = $clog2(STACK_BYTES + 1);
  localparam int ROW_N = (STACK_BYTES + 1) / 2;
  localparam int ROW_W = $clog2(ROW_N);
  localparam int CD_W  = $clog2(CALL_DEPTH + 1);
  localparam int IDX_W = (CALL_DEPTH > 1) ? $clog2(CALL_DEPTH) : 1;
  localparam int REC_W = WORD_W + 2 * PTR_W;
  localparam int AT_W  = ((PTR_W > WORD_W) ? PTR_W : WORD_W) + 2;

  localparam logic [PTR_W:0]    SB_LIM  = (PTR_W + 1)'(STACK_BYTES);
  localparam logic [PTR_W:0]    WB_P    = (PTR_W + 1)'(WORD_BYTES);
  localparam logic [AT_W-1:0]   SB_AT   = AT_W'(STACK_BYTES);
  localparam logic [AT_W-1:0]   WB_AT   = AT_W'(WORD_BYTES);
  localparam logic [CD_W-1:0]   CD_MAX  = CD_W'(CALL_DEPTH);
  localparam logic [ROW_W-1:0]  ROW_END = ROW_W'(ROW_N - 1);
  localparam logic [WORD_W-1:0] PC_OP   = WORD_W'(OPCODE_BYTES);
  localparam logic [WORD_W-1:0] PC_OPW  = WORD_W'(OPCODE_BYTES + WORD_BYTES);

  state_t            state_r;
  state_t            state_nxt;
  logic              halted_r;
  logic              halted_nxt;
  logic [WORD_W-1:0] pc_r;
  logic [WORD_W-1:0] pc_nxt;
  logic [PTR_W-1:0]  sp_r;
  logic [PTR_W-1:0]  sp_nxt;
  logic [PTR_W-1:0]  fp_r;
  logic [PTR_W-1:0]  fp_nxt;
  logic [CD_W-1:0]   depth_r;
  logic [CD_W-1:0]   depth_nxt;
  logic [ROW_W-1:0]  clr_r;
  logic [ROW_W-1:0]  clr_nxt;
  logic              out_vld_r;
  logic              out_vld_nxt;
  req_t              cur_r;
  req_t              cur_nxt;
  logic              odd_r;
  logic              odd_nxt;
  logic              fbad_r;
  logic              fbad_nxt;
  res_t              res_r;
  res_t              res_nxt;

  logic              dispatch;
  logic [AT_W-1:0]   at;
  logic [PTR_W-1:0]  sp_m2;

  logic              st_we;
  logic [ROW_W-1:0]  st_wrow;
  logic [7:0]        st_wlo;
  logic [7:0]        st_whi;
  logic [ROW_W-1:0]  ev_ra;
  logic [ROW_W-1:0]  od_ra;
  logic [7:0]        ev_q;
  logic [7:0]        od_q;

  logic              cr_we;
  logic [IDX_W-1:0]  cr_wa;
  logic [REC_W-1:0]  cr_wd;
  logic [IDX_W-1:0]  cr_ra;
  logic [REC_W-1:0]  cr_q;

  logic [WORD_W-1:0] rec_pc;
  logic [PTR_W-1:0]  rec_sp;
  logic [PTR_W-1:0]  rec_fp;
  logic [WORD_W-1:0] word_pop;
  logic [WORD_W-1:0] word_retv;
  logic [WORD_W-1:0] rslt;
  fault_t            flt;

  // Even bytes and odd bytes live in separate banks so that one word,
  // aligned or not, is read in a single access.
  svcr_ram #(.WIDTH(8), .DEPTH(ROW_N)) u_even (
    .clk   (clk),
    .we    (st_we),
    .waddr (st_wrow),
    .wdata (st_wlo),
    .raddr (ev_ra),
    .rdata (ev_q)
  );

  svcr_ram #(.WIDTH(8), .DEPTH(ROW_N)) u_odd (
    .clk   (clk),
    .we    (st_we),
    .waddr (st_wrow),
    .wdata (st_whi),
    .raddr (od_ra),
    .rdata (od_q)
  );

  svcr_ram #(.WIDTH(REC_W), .DEPTH(CALL_DEPTH)) u_calls (
    .clk   (clk),
    .we    (cr_we),
    .waddr (cr_wa),
    .wdata (cr_wd),
    .raddr (cr_ra),
    .rdata (cr_q)
  );

  assign dispatch = (state_r == S_IDLE) && bq_vld && (!out_vld_r || out_ch.ready);
  assign bq_rdy   = dispatch;
  assign at       = AT_W'(fp_r) + AT_W'(bq_req.operand);
  assign sp_m2    = sp_r - PTR_W'(WORD_BYTES);

  assign ev_ra = (bq_req.op == OP_POP) ? sp_m2[ROW_W:1] :
                 (at[0] ? at[ROW_W:1] + 1'b1 : at[ROW_W:1]);
  assign od_ra = (bq_req.op == OP_POP) ? sp_m2[ROW_W:1] : at[ROW_W:1];
  assign cr_ra = IDX_W'(depth_r - 1'b1);

  assign rec_pc    = cr_q[REC_W-1 -: WORD_W];
  assign rec_sp    = cr_q[2*PTR_W-1 -: PTR_W];
  assign rec_fp    = cr_q[PTR_W-1:0];
  assign word_pop  = {od_q, ev_q};
  assign word_retv = odd_r ? {ev_q, od_q} : {od_q, ev_q};

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_CLEAR: begin
        if (clr_r == ROW_END) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (dispatch) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC:  state_nxt = S_IDLE;
      default: state_nxt = S_CLEAR;
    endcase
  end

  always_comb begin
    halted_nxt  = halted_r;
    pc_nxt      = pc_r;
    sp_nxt      = sp_r;
    fp_nxt      = fp_r;
    depth_nxt   = depth_r;
    clr_nxt     = clr_r;
    out_vld_nxt = out_vld_r && !out_ch.ready;
    cur_nxt     = cur_r;
    odd_nxt     = odd_r;
    fbad_nxt    = fbad_r;
    res_nxt     = res_r;
    st_we       = 1'b0;
    st_wrow     = sp_r[ROW_W:1];
    st_wlo      = cur_r.operand[7:0];
    st_whi      = cur_r.operand[15:8];
    cr_we       = 1'b0;
    cr_wa       = IDX_W'(depth_r);
    cr_wd       = {pc_r + PC_OPW, sp_r, fp_r};
    rslt        = '0;
    flt         = FAULT_NONE;
    case (state_r)
      S_CLEAR: begin
        st_we   = 1'b1;
        st_wrow = clr_r;
        st_wlo  = '0;
        st_whi  = '0;
        clr_nxt = clr_r + 1'b1;
      end
      S_IDLE: begin
        if (dispatch) begin
          cur_nxt  = bq_req;
          odd_nxt  = at[0];
          fbad_nxt = (at + WB_AT) > SB_AT;
        end
      end
      S_EXEC: begin
        out_vld_nxt = 1'b1;
        if (!halted_r) begin
          case (cur_r.op)
            OP_HALT: begin
              pc_nxt     = pc_r + PC_OP;
              halted_nxt = 1'b1;
            end
            OP_PUSH: begin
              if (({1'b0, sp_r} + WB_P) > SB_LIM) begin
                flt = FAULT_STACK_OVF;
              end else begin
                st_we  = 1'b1;
                sp_nxt = sp_r + PTR_W'(WORD_BYTES);
                pc_nxt = pc_r + PC_OPW;
                rslt   = cur_r.operand;
              end
            end
            OP_POP: begin
              if (sp_r < PTR_W'(WORD_BYTES)) begin
                flt = FAULT_STACK_UNF;
              end else begin
                sp_nxt = sp_m2;
                rslt   = word_pop;
                pc_nxt = pc_r + PC_OP;
              end
            end
            OP_CALL: begin
              if (depth_r >= CD_MAX) begin
                flt = FAULT_CALL_OVF;
              end else begin
                cr_we     = 1'b1;
                depth_nxt = depth_r + 1'b1;
                pc_nxt    = cur_r.operand;
                fp_nxt    = sp_r;
              end
            end
            OP_RETN: begin
              if (depth_r == '0) begin
                flt = FAULT_CALL_UNF;
              end else begin
                depth_nxt = depth_r - 1'b1;
                pc_nxt    = rec_pc;
                sp_nxt    = rec_sp;
                fp_nxt    = rec_fp;
              end
            end
            OP_RETV: begin
              if (depth_r == '0) begin
                flt = FAULT_CALL_UNF;
              end else if (fbad_r) begin
                flt = FAULT_FRAME;
              end else if (({1'b0, rec_sp} + WB_P) > SB_LIM) begin
                flt = FAULT_STACK_OVF;
              end else begin
                rslt      = word_retv;
                depth_nxt = depth_r - 1'b1;
                st_we     = 1'b1;
                st_wrow   = rec_sp[ROW_W:1];
                st_wlo    = word_retv[7:0];
                st_whi    = word_retv[15:8];
                sp_nxt    = rec_sp + PTR_W'(WORD_BYTES);
                pc_nxt    = rec_pc;
                fp_nxt    = rec_fp;
              end
            end
            default: begin
              pc_nxt = pc_r + PC_OP;
            end
          endcase
        end
        res_nxt.next_address = pc_nxt;
        res_nxt.result_value = rslt;
        res_nxt.stack_level  = LEVEL_W'(sp_nxt);
        res_nxt.frame_level  = LEVEL_W'(fp_nxt);
        res_nxt.call_level   = CALL_W'(depth_nxt);
        res_nxt.is_halted    = halted_nxt;
        res_nxt.fault        = flt;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_CLEAR;
      halted_r  <= 1'b0;
      pc_r      <= '0;
      sp_r      <= '0;
      fp_r      <= '0;
      depth_r   <= '0;
      clr_r     <= '0;
      out_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      halted_r  <= halted_nxt;
      pc_r      <= pc_nxt;
      sp_r      <= sp_nxt;
      fp_r      <= fp_nxt;
      depth_r   <= depth_nxt;
      clr_r     <= clr_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r  <= cur_nxt;
    odd_r  <= odd_nxt;
    fbad_r <= fbad_nxt;
    res_r  <= res_nxt;
  end

  assign out_ch.valid        = out_vld_r;
  assign out_ch.next_address = res_r.next_address;
  assign out_ch.result_value = res_r.result_value;
  assign out_ch.stack_level  = res_r.stack_level;
  assign out_ch.frame_level  = res_r.frame_level;
  assign out_ch.call_level   = res_r.call_level;
  assign out_ch.is_halted    = res_r.is_halted;
  assign out_ch.fault        = res_r.fault;

  assign stat.clearing = state_r == S_CLEAR;
  assign stat.halted   = halted_r;

endmodule

@@ hdl/stack_vm_call_return_core.sv @@
// The execute unit takes a new instruction only once the current one is done,
// as it reads and then writes the byte-stack and call-record memories.
// Reset: synchronous; after reset the byte stack is zeroed by a sweep of
// (STACK_BYTES+1)/2 rows (128 by default) before the first instruction runs;
// requests are still taken into the front and queue during the sweep.
// ----------------------------------------------------------------------------
// stack_vm_call_return_core
// Stack-machine core with push, pop, call and return; front decode, request
// queue and execute back end.
// ----------------------------------------------------------------------------
`include "stack_vm_call_return_core_defines.svh"

module stack_vm_call_return_core import svcr_pkg::*; #(
  parameter int STACK_BYTES  = SVCR_STACK_BYTES,
  parameter int CALL_DEPTH   = SVCR_CALL_DEPTH,
  parameter int OPCODE_BYTES = SVCR_OPCODE_BYTES
) (
  input  logic       clk,
  input  logic       rst_n,
  svcr_in_if.sink    in_ch,
  svcr_out_if.source out_ch
);

  logic     fq_vld;
  logic     fq_rdy;
  req_t     fq_req;
  logic     bq_vld;
  logic     bq_rdy;
  req_t     bq_req;
  bk_stat_t bk_stat;

  svcr_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .fq_vld (fq_vld),
    .fq_rdy (fq_rdy),
    .fq_req (fq_req)
  );

  svcr_queue u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .wr_vld (fq_vld),
    .wr_rdy (fq_rdy),
    .wr_req (fq_req),
    .rd_vld (bq_vld),
    .rd_rdy (bq_rdy),
    .rd_req (bq_req)
  );

  svcr_back #(
    .STACK_BYTES  (STACK_BYTES),
    .CALL_DEPTH   (CALL_DEPTH),
    .OPCODE_BYTES (OPCODE_BYTES)
  ) u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .bq_vld (bq_vld),
    .bq_rdy (bq_rdy),
    .bq_req (bq_req),
    .out_ch (out_ch),
    .stat   (bk_stat)
  );

  `SVCR_ASSERT(a_no_exec_in_clear, clk, rst_n, bk_stat.clearing |-> !(bq_vld && bq_rdy))
  `SVCR_ASSERT(a_fault_zero_value, clk, rst_n, (out_ch.valid && out_ch.fault != FAULT_NONE) |-> out_ch.result_value == 16'd0)
  `SVCR_ASSERT(a_halted_no_fault, clk, rst_n, (out_ch.valid && out_ch.is_halted) |-> out_ch.fault == FAULT_NONE)
  `SVCR_ASSERT_NORST(a_halt_sticky, clk, ($past(rst_n) && rst_n && $past(bk_stat.halted)) |-> bk_stat.halted)

endmodule
